// ===== rtl/core/nrlp_pkg.sv =====
// Package for the nearest-neighbor resampling loop player.
// Holds the word types, configuration bundle, action and register codes.
// No dependencies.
`default_nettype none

package nrlp_pkg;

  // Default frame store depth
  localparam int unsigned MAX_FRAMES_DEF = 16384;

  // Output rates
  localparam logic [15:0] RATE_HIGH = 16'd44100;
  localparam logic [15:0] RATE_LOW  = 16'd22050;

  // Position remainder plus source rate needs 19 bits
  localparam int unsigned REM_W = 19;

  // Action codes
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_EMIT    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_SOURCE_RATE   = 2'd0;
  localparam logic [1:0] REG_FRAME_COUNT   = 2'd1;
  localparam logic [1:0] REG_LOOPING       = 2'd2;
  localparam logic [1:0] REG_STEREO_SOURCE = 2'd3;

  // Configuration reset values
  localparam logic [17:0] SOURCE_RATE_RST = 18'd44100;
  localparam logic [14:0] FRAME_COUNT_RST = 15'd1;

  typedef struct packed {
    logic [1:0]         action;
    logic [13:0]        frame_index;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic               ended;
  } out_word_t;

  typedef struct packed {
    logic [17:0] source_rate;
    logic [14:0] frame_count;
    logic        looping;
    logic        stereo_source;
  } cfg_t;

  // Frame store strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/nrlp_frame_mem.sv =====
// Frame store: one write port, one registered read port.
// Uses nrlp_pkg for the strobe bundle.
`default_nettype none

module nrlp_frame_mem #(
  parameter int unsigned Depth = nrlp_pkg::MAX_FRAMES_DEF,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire                    clk_i,
  input  nrlp_pkg::mem_ctl_t     ctl_i,
  input  wire  [AddrW-1:0]       waddr_i,
  input  wire  [31:0]            wdata_i,
  input  wire  [AddrW-1:0]       raddr_i,
  output logic [31:0]            rdata_o
);

  logic [31:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/nrlp_seq.sv =====
// Sequencer: position and phase tracking, wrap, store access and output register.
// Uses nrlp_pkg; drives the frame store in nrlp_frame_mem.
`default_nettype none

module nrlp_seq #(
  parameter int unsigned MaxFrames = nrlp_pkg::MAX_FRAMES_DEF,
  parameter int unsigned AddrW     = $clog2(MaxFrames)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  nrlp_pkg::in_word_t    in_word_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output nrlp_pkg::out_word_t   out_word_o,
  input  nrlp_pkg::cfg_t        cfg_i,
  output nrlp_pkg::mem_ctl_t    mem_ctl_o,
  output logic [AddrW-1:0]      mem_waddr_o,
  output logic [31:0]           mem_wdata_o,
  output logic [AddrW-1:0]      mem_raddr_o,
  input  wire  [31:0]           mem_rdata_i
);

  localparam int unsigned PosW = AddrW + 1;
  localparam int unsigned CntW = $clog2(PosW);
  localparam int unsigned RemW = nrlp_pkg::REM_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FOLD0 = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_DATA  = 3'd5;
  localparam logic [2:0] S_FOLD1 = 3'd6;
  localparam logic [2:0] S_END   = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic                ended_q, ended_d;
  logic [PosW-1:0]     mod_q, mod_d;
  logic [CntW-1:0]     step_q, step_d;
  logic                out_valid_q, out_valid_d;
  nrlp_pkg::out_word_t out_word_q, out_word_d;

  logic [RemW-1:0]     rate;
  logic [PosW-1:0]     count;
  logic                out_free;
  logic                in_acc;
  logic [PosW-1:0]     mod_shift;
  logic signed [15:0]  rd_left;
  logic signed [15:0]  rd_right;

  // Output rate and clamped frame count
  assign rate = (cfg_i.source_rate >= 18'(nrlp_pkg::RATE_HIGH)) ?
                RemW'(nrlp_pkg::RATE_HIGH) : RemW'(nrlp_pkg::RATE_LOW);
  assign count = (32'(cfg_i.frame_count) > MaxFrames) ? PosW'(MaxFrames)
                                                      : PosW'(cfg_i.frame_count);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Restoring remainder step: bring in the next dividend bit
  assign mod_shift = {mod_q[PosW-2:0], pos_q[PosW-1]};

  assign rd_left  = mem_rdata_i[15:0];
  assign rd_right = cfg_i.stereo_source ? mem_rdata_i[31:16] : mem_rdata_i[15:0];

  // Store write from a load word, read at the current frame
  always_comb begin
    mem_ctl_o.wr_en = in_acc && (in_word_i.action == nrlp_pkg::ACT_LOAD) &&
                      (32'(in_word_i.frame_index) < MaxFrames);
    mem_ctl_o.rd_en = (state_q == S_READ);
    mem_waddr_o     = AddrW'(in_word_i.frame_index);
    mem_wdata_o     = {in_word_i.right_sample, in_word_i.left_sample};
    mem_raddr_o     = pos_q[AddrW-1:0];
  end

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    ended_d     = ended_q;
    mod_d       = mod_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_word_i.action == nrlp_pkg::ACT_EMIT) begin
            state_d = ended_q ? S_END : S_FOLD0;
          end else if (in_word_i.action == nrlp_pkg::ACT_RESTART) begin
            pos_d   = '0;
            rem_d   = '0;
            ended_d = 1'b0;
          end
        end
      end
      // Fold remainder for the current rate, one frame a cycle
      S_FOLD0: begin
        if (rem_q >= rate) begin
          rem_d = rem_q - rate;
          pos_d = pos_q + PosW'(1);
        end else begin
          state_d = S_CHECK;
        end
      end
      // End-of-clip check: stop, wrap, or go on to the read
      S_CHECK: begin
        if (count == '0) begin
          ended_d = 1'b1;
          state_d = S_END;
        end else if (pos_q >= count) begin
          if (cfg_i.looping) begin
            mod_d   = '0;
            step_d  = CntW'(PosW - 1);
            state_d = S_MOD;
          end else begin
            ended_d = 1'b1;
            state_d = S_END;
          end
        end else begin
          state_d = S_READ;
        end
      end
      // pos mod count, one bit a cycle; pos shifts out as the remainder builds
      S_MOD: begin
        mod_d = (mod_shift >= count) ? (mod_shift - count) : mod_shift;
        pos_d = {pos_q[PosW-2:0], 1'b0};
        if (step_q == '0) begin
          pos_d   = mod_d;
          state_d = S_READ;
        end else begin
          step_d = step_q - CntW'(1);
        end
      end
      S_READ: begin
        state_d = S_DATA;
      end
      // Frame word back from the store
      S_DATA: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_word_d.out_left  = rd_left;
          out_word_d.out_right = rd_right;
          out_word_d.ended     = 1'b0;
          rem_d                = rem_q + RemW'(cfg_i.source_rate);
          state_d              = S_FOLD1;
        end
      end
      // Fold after the advance
      S_FOLD1: begin
        if (rem_q >= rate) begin
          rem_d = rem_q - rate;
          pos_d = pos_q + PosW'(1);
        end else begin
          state_d = S_IDLE;
        end
      end
      S_END: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = '{out_left: '0, out_right: '0, ended: 1'b1};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      rem_q       <= '0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      rem_q       <= rem_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mod_q      <= mod_d;
    step_q     <= step_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

// ===== rtl/core/nearest_resample_loop_player.sv =====
// Top level of the nearest-neighbor resampling loop player.
// Holds the configuration registers; uses nrlp_pkg, nrlp_seq and nrlp_frame_mem.
//
//  Channel | Signals                          | Handshake
//  --------+----------------------------------+------------------------
//  in      | in_valid_i, in_stall_o, in_word  | accept: valid & !stall
//  out     | out_valid_o, out_stall_i, out_w. | accept: valid & !stall
//  cfg     | cfg_valid_i, cfg_ready_o, index  | write: valid & ready
//
// Load and restart words are taken in idle and do not stall input. An emit word
// folds frames from the phase remainder (FOLD0), checks the end (CHECK), takes
// one restoring remainder step per position bit on a looping wrap (MOD), reads
// the store (READ, DATA) and folds again (FOLD1); an ended clip answers from END.
// Reset clears position, phase and the ended flag; store contents stay undefined
// until loaded. A stalled output word holds the next result while new words wait.
`default_nettype none

module nearest_resample_loop_player #(
  parameter int unsigned MaxFrames = nrlp_pkg::MAX_FRAMES_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  nrlp_pkg::in_word_t   in_word_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output nrlp_pkg::out_word_t  out_word_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire  [1:0]           cfg_index_i,
  input  wire  [17:0]          cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MaxFrames);

  nrlp_pkg::cfg_t     cfg_q;
  nrlp_pkg::mem_ctl_t mem_ctl;
  logic [AddrW-1:0]   mem_waddr;
  logic [AddrW-1:0]   mem_raddr;
  logic [31:0]        mem_wdata;
  logic [31:0]        mem_rdata;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_rate   <= nrlp_pkg::SOURCE_RATE_RST;
      cfg_q.frame_count   <= nrlp_pkg::FRAME_COUNT_RST;
      cfg_q.looping       <= 1'b0;
      cfg_q.stereo_source <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        nrlp_pkg::REG_SOURCE_RATE:   cfg_q.source_rate   <= cfg_data_i;
        nrlp_pkg::REG_FRAME_COUNT:   cfg_q.frame_count   <= cfg_data_i[14:0];
        nrlp_pkg::REG_LOOPING:       cfg_q.looping       <= cfg_data_i[0];
        nrlp_pkg::REG_STEREO_SOURCE: cfg_q.stereo_source <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  nrlp_seq #(
    .MaxFrames (MaxFrames),
    .AddrW     (AddrW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_i       (cfg_q),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  nrlp_frame_mem #(
    .Depth (MaxFrames),
    .AddrW (AddrW)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
